>>> rtl/bpp_pkg.sv
// ---------------------------------------------------------------------------
// bpp_pkg
// Shared types, constants and helpers of the Boris particle push block.
// ---------------------------------------------------------------------------
package bpp_pkg;

    // default geometry and storage width
    localparam int GRID_N_DEF      = 32;
    localparam int FIELD_WIDTH_DEF = 32;

    // fixed field widths, component count and queue depth
    localparam int CELL_W      = 5;
    localparam int FRAC_W      = 16;
    localparam int VEL_W       = 32;
    localparam int SEL_W       = 3;
    localparam int COMP_NUM    = 6;
    localparam int QUEUE_DEPTH = 2;

    // request types
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_PUSH  = 1'b1;

    // configuration register indexes
    localparam logic CFG_HQM = 1'b0;
    localparam logic CFG_MAG = 1'b1;

    // classification done by the front end
    typedef enum logic [1:0] {
        ITEM_WRITE,
        ITEM_SKIP,
        ITEM_PUSH,
        ITEM_OUTSIDE
    } item_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_SAT     = 2'd1,
        STATUS_OUTSIDE = 2'd2
    } push_status_t;

    // queued item between front and back
    typedef struct packed {
        item_kind_t                kind;
        logic [CELL_W-1:0]         cell_x;
        logic [CELL_W-1:0]         cell_y;
        logic [CELL_W-1:0]         cell_z;
        logic [FRAC_W-1:0]         frac_x;
        logic [FRAC_W-1:0]         frac_y;
        logic [FRAC_W-1:0]         frac_z;
        logic signed [VEL_W-1:0]   vel_x;
        logic signed [VEL_W-1:0]   vel_y;
        logic signed [VEL_W-1:0]   vel_z;
        logic [SEL_W-1:0]          field_select;
        logic signed [VEL_W-1:0]   field_value;
    } item_t;

    // configuration seen by the back end
    typedef struct packed {
        logic signed [31:0] hqm;
        logic               mag_en;
    } cfg_t;

    // push sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_WGT_A,
        S_WGT_B,
        S_WGT_C,
        S_GATH,
        S_GROUND,
        S_GSCALE,
        S_GSAT,
        S_V1,
        S_CROSS,
        S_VT,
        S_DEN,
        S_WAIT_DIV,
        S_ROT,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               ovf;
    } sat_t;

    localparam logic signed [71:0] SAT_HI = 72'sh7FFFFFFF;
    localparam logic signed [71:0] SAT_LO = {{40{1'b1}}, 1'b1, 31'b0};

    // clamp to signed 32 bits and report the clamp
    function automatic sat_t sat32(input logic signed [71:0] v);
        sat_t r;
        r.val = v[31:0];
        r.ovf = 1'b0;
        if (v > SAT_HI)
        begin
            r.val = 32'sh7FFFFFFF;
            r.ovf = 1'b1;
        end
        else if (v < SAT_LO)
        begin
            r.val = 32'sh80000000;
            r.ovf = 1'b1;
        end
        return r;
    endfunction

endpackage

>>> rtl/bpp_front.sv
// ---------------------------------------------------------------------------
// bpp_front
// Accepts requests, classifies them and holds them in a short queue.
// ---------------------------------------------------------------------------
module bpp_front import bpp_pkg::*; #(
    parameter int GRID_N = GRID_N_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  logic                     req_type,
    input  logic [CELL_W-1:0]        cell_x,
    input  logic [CELL_W-1:0]        cell_y,
    input  logic [CELL_W-1:0]        cell_z,
    input  logic [FRAC_W-1:0]        frac_x,
    input  logic [FRAC_W-1:0]        frac_y,
    input  logic [FRAC_W-1:0]        frac_z,
    input  logic signed [VEL_W-1:0]  vel_x,
    input  logic signed [VEL_W-1:0]  vel_y,
    input  logic signed [VEL_W-1:0]  vel_z,
    input  logic [SEL_W-1:0]         field_select,
    input  logic signed [VEL_W-1:0]  field_value,
    output logic                     q_valid,
    input  logic                     q_ready,
    output item_t                    q_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push_q;
    logic               pop_q;
    logic               in_grid;
    logic               push_inside;
    item_t              item_in;

    // classification of the incoming transaction
    always_comb
    begin
        in_grid     = (32'(cell_x) < GRID_N) && (32'(cell_y) < GRID_N)
                      && (32'(cell_z) < GRID_N);
        push_inside = (32'(cell_x) + 32'd1 < GRID_N) && (32'(cell_y) + 32'd1 < GRID_N)
                      && (32'(cell_z) + 32'd1 < GRID_N);
        item_in.cell_x       = cell_x;
        item_in.cell_y       = cell_y;
        item_in.cell_z       = cell_z;
        item_in.frac_x       = frac_x;
        item_in.frac_y       = frac_y;
        item_in.frac_z       = frac_z;
        item_in.vel_x        = vel_x;
        item_in.vel_y        = vel_y;
        item_in.vel_z        = vel_z;
        item_in.field_select = field_select;
        item_in.field_value  = field_value;
        priority if (req_type == REQ_PUSH)
            item_in.kind = push_inside ? ITEM_PUSH : ITEM_OUTSIDE;
        else if (in_grid && (field_select <= SEL_W'(COMP_NUM - 1)))
            item_in.kind = ITEM_WRITE;
        else
            item_in.kind = ITEM_SKIP;
    end

    // queue handshakes
    assign req_ready = (count_reg < CNT_W'(QUEUE_DEPTH));
    assign push_q    = req_valid && req_ready;
    assign q_valid   = (count_reg != '0);
    assign pop_q     = q_valid && q_ready;
    assign q_item    = q_mem_reg[rd_ptr_reg];

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_q)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            if (pop_q)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            if (push_q && !pop_q)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop_q && !push_q)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push_q)
            q_mem_reg[wr_ptr_reg] <= item_in;
    end

endmodule

>>> rtl/bpp_div.sv
// ---------------------------------------------------------------------------
// bpp_div
// Restoring divider for the rotation factor 2^63 / den, one bit per cycle.
// ---------------------------------------------------------------------------
module bpp_div import bpp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] den,
    output logic        busy,
    output logic [31:0] quot
);

    logic [63:0] rem_reg;
    logic [63:0] dvs_reg;
    logic [31:0] quot_reg;
    logic [5:0]  step_reg;
    logic [64:0] shifted;
    logic [65:0] diff;
    logic        ge;

    // one trial subtraction per cycle
    assign shifted = {rem_reg, 1'b0};
    assign diff    = {1'b0, shifted} - {2'b0, dvs_reg};
    assign ge      = !diff[65];
    assign busy    = (step_reg != '0);
    assign quot    = quot_reg;

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (start)
            step_reg <= 6'd32;
        else if (busy)
            step_reg <= step_reg - 6'd1;
    end

    // remainder and quotient; dividend is 2^63, so only its top half is nonzero
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= 64'h0000_0000_8000_0000;
            dvs_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy)
        begin
            rem_reg  <= ge ? diff[63:0] : shifted[63:0];
            quot_reg <= {quot_reg[30:0], ge};
        end
    end

endmodule

>>> rtl/bpp_back.sv
// ---------------------------------------------------------------------------
// bpp_back
// Field memory, trilinear gather and Boris update on one shared multiplier.
// ---------------------------------------------------------------------------
module bpp_back import bpp_pkg::*; #(
    parameter int GRID_N      = GRID_N_DEF,
    parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  item_t                    q_item,
    input  cfg_t                     cfg,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output logic signed [VEL_W-1:0]  new_vel_x,
    output logic signed [VEL_W-1:0]  new_vel_y,
    output logic signed [VEL_W-1:0]  new_vel_z,
    output logic [1:0]               push_status
);

    localparam int PLANE     = GRID_N * GRID_N;
    localparam int NODE_N    = GRID_N * GRID_N * GRID_N;
    localparam int MEM_DEPTH = COMP_NUM * NODE_N;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int STORE_W   = (FIELD_WIDTH < VEL_W) ? FIELD_WIDTH : VEL_W;

    localparam logic signed [57:0] ACC_RND = 58'sd8388608;
    localparam logic signed [66:0] RND15   = 67'sd32768;
    localparam logic signed [66:0] RND23   = 67'sd8388608;
    localparam logic signed [66:0] RND29   = 67'sd536870912;

    seq_state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [2:0] comp_reg, comp_next;
    logic       cross_reg, cross_next;

    // field memory
    logic [STORE_W-1:0]        mem [MEM_DEPTH];
    logic [STORE_W-1:0]        rdata_reg;
    logic signed [STORE_W-1:0] rword;
    logic                      mem_we;
    logic                      mem_re;
    logic [AW-1:0]             mem_waddr;
    logic [AW-1:0]             mem_raddr;
    logic [AW-1:0]             base_calc;
    logic [AW-1:0]             base_reg;
    logic [AW-1:0]             corner_off;

    // datapath
    item_t                     item_reg;
    logic [24:0]               wgt_reg [8];
    logic signed [57:0]        acc_reg;
    logic signed [33:0]        g_reg;
    logic signed [31:0]        e_reg  [3];
    logic signed [31:0]        b_reg  [3];
    logic signed [31:0]        v_in   [3];
    logic signed [31:0]        v1_reg [3];
    logic signed [31:0]        vt_reg [3];
    logic signed [31:0]        c_reg  [3];
    logic signed [31:0]        res_reg[3];
    logic signed [66:0]        hold_reg;
    logic [63:0]               den_reg;
    logic                      flag_reg;

    // shared multiplier
    logic signed [33:0]        mul_a;
    logic signed [32:0]        mul_b;
    logic signed [66:0]        prod_reg;
    logic [16:0]               wx, wy, wz;
    logic [2:0]                gidx;
    logic [1:0]                ja, jb;
    logic [1:0]                ridx;
    logic signed [31:0]        xa_op;
    logic signed [31:0]        xb_op;

    // rounding taps
    logic signed [57:0]        g_round;
    logic signed [66:0]        scale_full;
    logic signed [66:0]        cross_full;
    logic signed [66:0]        rot_full;
    sat_t                      scale_sat;
    sat_t                      cross_sat;
    sat_t                      rot_sat;

    // divider
    logic                      div_start;
    logic                      div_busy;
    logic [31:0]               factor;

    // output register
    logic                      rsp_valid_reg;
    logic                      rsp_load;
    logic signed [VEL_W-1:0]   out_x_reg, out_y_reg, out_z_reg;
    push_status_t              status_reg;

    bpp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (den_reg),
        .busy  (div_busy),
        .quot  (factor)
    );

    // node address of the base cell
    assign base_calc = AW'(q_item.cell_x) * AW'(PLANE) + AW'(q_item.cell_y) * AW'(GRID_N)
                       + AW'(q_item.cell_z);

    // corner offsets: bit0 x, bit1 y, bit2 z
    assign corner_off = (cnt_reg[0] ? AW'(PLANE) : AW'(0)) + (cnt_reg[1] ? AW'(GRID_N) : AW'(0))
                        + (cnt_reg[2] ? AW'(1) : AW'(0));
    assign mem_raddr  = AW'(comp_reg) * AW'(NODE_N) + base_reg + corner_off;
    assign mem_waddr  = AW'(item_reg.field_select) * AW'(NODE_N) + base_reg;
    assign rword      = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= item_reg.field_value[STORE_W-1:0];
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    // axis weights and operand picks
    always_comb
    begin
        v_in[0] = item_reg.vel_x;
        v_in[1] = item_reg.vel_y;
        v_in[2] = item_reg.vel_z;
        wx   = cnt_reg[0] ? {1'b0, item_reg.frac_x} : 17'h10000 - {1'b0, item_reg.frac_x};
        wy   = cnt_reg[1] ? {1'b0, item_reg.frac_y} : 17'h10000 - {1'b0, item_reg.frac_y};
        wz   = cnt_reg[2] ? {1'b0, item_reg.frac_z} : 17'h10000 - {1'b0, item_reg.frac_z};
        gidx = 3'(cnt_reg - 4'd1);
        ridx = 2'(cnt_reg - 4'd1);
        unique case (cnt_reg[2:1])
            2'd0:
            begin
                ja = 2'd1;
                jb = 2'd2;
            end
            2'd1:
            begin
                ja = 2'd2;
                jb = 2'd0;
            end
            2'd2:
            begin
                ja = 2'd0;
                jb = 2'd1;
            end
            default:
            begin
                ja = 2'd0;
                jb = 2'd0;
            end
        endcase
        // even step: a[i+1]*b[i+2], odd step: a[i+2]*b[i+1]
        if (cnt_reg[0])
        begin
            xa_op = cross_reg ? vt_reg[jb] : v1_reg[jb];
            xb_op = b_reg[ja];
        end
        else
        begin
            xa_op = cross_reg ? vt_reg[ja] : v1_reg[ja];
            xb_op = b_reg[jb];
        end
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_WGT_A:
            begin
                mul_a = 34'(wx);
                mul_b = 33'(wy);
            end
            S_WGT_B:
            begin
                mul_a = {1'b0, prod_reg[32:0]};
                mul_b = 33'(wz);
            end
            S_GATH:
            begin
                mul_a = 34'(wgt_reg[gidx]);
                mul_b = 33'(rword);
            end
            S_GSCALE:
            begin
                mul_a = g_reg;
                mul_b = 33'(cfg.hqm);
            end
            S_CROSS:
            begin
                mul_a = 34'(xa_op);
                mul_b = 33'(xb_op);
            end
            S_DEN:
            begin
                if (cnt_reg < 4'd3)
                begin
                    mul_a = 34'(b_reg[cnt_reg[1:0]]);
                    mul_b = 33'(b_reg[cnt_reg[1:0]]);
                end
            end
            S_ROT:
            begin
                if (cnt_reg < 4'd3)
                begin
                    mul_a = 34'(factor);
                    mul_b = 33'(c_reg[cnt_reg[1:0]]);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // rounding and clamps
    assign g_round    = (acc_reg + ACC_RND) >>> 24;
    assign scale_full = (prod_reg + RND23) >>> 24;
    assign cross_full = (hold_reg - prod_reg + RND15) >>> 16;
    assign rot_full   = (prod_reg + RND29) >>> 30;
    assign scale_sat  = sat32(72'(scale_full));
    assign cross_sat  = sat32(72'(cross_full));
    assign rot_sat    = sat32(72'(v1_reg[ridx]) + 72'(e_reg[ridx]) + 72'(rot_full));

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        cross_next = cross_reg;
        q_ready    = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        div_start  = 1'b0;
        rsp_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    cnt_next   = '0;
                    comp_next  = '0;
                    cross_next = 1'b0;
                    unique case (q_item.kind)
                        ITEM_WRITE: state_next = S_WRITE;
                        ITEM_PUSH:  state_next = S_WGT_A;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_WRITE:
            begin
                mem_we     = 1'b1;
                state_next = S_DONE;
            end
            S_WGT_A: state_next = S_WGT_B;
            S_WGT_B: state_next = S_WGT_C;
            S_WGT_C:
            begin
                if (cnt_reg == 4'd7)
                begin
                    cnt_next   = '0;
                    state_next = S_GATH;
                end
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = S_WGT_A;
                end
            end
            S_GATH:
            begin
                mem_re = (cnt_reg < 4'd8);
                if (cnt_reg == 4'd9)
                begin
                    cnt_next   = '0;
                    state_next = S_GROUND;
                end
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            S_GROUND: state_next = S_GSCALE;
            S_GSCALE: state_next = S_GSAT;
            S_GSAT:
            begin
                if ((comp_reg == 3'(COMP_NUM - 1)) || ((comp_reg == 3'd2) && !cfg.mag_en))
                    state_next = S_V1;
                else
                begin
                    comp_next  = comp_reg + 3'd1;
                    state_next = S_GATH;
                end
            end
            S_V1:
            begin
                cnt_next   = '0;
                cross_next = 1'b0;
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                // second rotation overlaps the divider
                div_start = cross_reg && (cnt_reg == 4'd0);
                if (cnt_reg == 4'd6)
                begin
                    cnt_next   = '0;
                    state_next = cross_reg ? S_WAIT_DIV : S_VT;
                end
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            S_VT:
            begin
                cnt_next   = '0;
                state_next = S_DEN;
            end
            S_DEN:
            begin
                if (cnt_reg == 4'd3)
                begin
                    cnt_next   = '0;
                    cross_next = 1'b1;
                    state_next = S_CROSS;
                end
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            S_WAIT_DIV:
            begin
                if (!div_busy)
                begin
                    cnt_next   = '0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                if (cnt_reg == 4'd3)
                    state_next = S_DONE;
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            comp_reg      <= '0;
            cross_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            comp_reg      <= comp_next;
            cross_reg     <= cross_next;
            rsp_valid_reg <= rsp_load || (rsp_valid_reg && !rsp_ready);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    item_reg <= q_item;
                    base_reg <= base_calc;
                    flag_reg <= 1'b0;
                    for (int i = 0; i < 3; i++)
                        b_reg[i] <= '0;
                end
            end
            S_WGT_C:
                wgt_reg[cnt_reg[2:0]] <= prod_reg[48:24];
            S_GATH:
            begin
                if (cnt_reg == 4'd0)
                    acc_reg <= '0;
                else if (cnt_reg >= 4'd2)
                    acc_reg <= acc_reg + prod_reg[57:0];
            end
            S_GROUND:
                g_reg <= g_round[33:0];
            S_GSAT:
            begin
                flag_reg <= flag_reg | scale_sat.ovf;
                if (comp_reg < 3'd3)
                    e_reg[comp_reg[1:0]] <= scale_sat.val;
                else
                    b_reg[2'(comp_reg - 3'd3)] <= scale_sat.val;
            end
            S_V1:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    v1_reg[i] <= sat32(72'(v_in[i]) + 72'(e_reg[i])).val;
                end
                flag_reg <= flag_reg | sat32(72'(v_in[0]) + 72'(e_reg[0])).ovf
                            | sat32(72'(v_in[1]) + 72'(e_reg[1])).ovf
                            | sat32(72'(v_in[2]) + 72'(e_reg[2])).ovf;
            end
            S_CROSS:
            begin
                if (cnt_reg != 4'd0)
                begin
                    if (cnt_reg[0])
                        hold_reg <= prod_reg;
                    else
                    begin
                        c_reg[2'(cnt_reg[3:1] - 3'd1)] <= cross_sat.val;
                        flag_reg <= flag_reg | cross_sat.ovf;
                    end
                end
            end
            S_VT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vt_reg[i] <= sat32(72'(v1_reg[i]) + 72'(c_reg[i])).val;
                end
                flag_reg <= flag_reg | sat32(72'(v1_reg[0]) + 72'(c_reg[0])).ovf
                            | sat32(72'(v1_reg[1]) + 72'(c_reg[1])).ovf
                            | sat32(72'(v1_reg[2]) + 72'(c_reg[2])).ovf;
            end
            S_DEN:
            begin
                if (cnt_reg == 4'd0)
                    den_reg <= 64'h0000_0001_0000_0000;
                else
                    den_reg <= den_reg + prod_reg[63:0];
            end
            S_ROT:
            begin
                if (cnt_reg != 4'd0)
                begin
                    res_reg[ridx] <= rot_sat.val;
                    flag_reg      <= flag_reg | rot_sat.ovf;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            unique case (item_reg.kind)
                ITEM_PUSH:
                begin
                    out_x_reg  <= res_reg[0];
                    out_y_reg  <= res_reg[1];
                    out_z_reg  <= res_reg[2];
                    status_reg <= flag_reg ? STATUS_SAT : STATUS_OK;
                end
                ITEM_OUTSIDE:
                begin
                    out_x_reg  <= item_reg.vel_x;
                    out_y_reg  <= item_reg.vel_y;
                    out_z_reg  <= item_reg.vel_z;
                    status_reg <= STATUS_OUTSIDE;
                end
                default:
                begin
                    out_x_reg  <= '0;
                    out_y_reg  <= '0;
                    out_z_reg  <= '0;
                    status_reg <= STATUS_OK;
                end
            endcase
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign new_vel_x   = out_x_reg;
    assign new_vel_y   = out_y_reg;
    assign new_vel_z   = out_z_reg;
    assign push_status = status_reg;

    // divider is never restarted while running
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // rotation factor is final before use
    a_rot_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROT) |-> !div_busy)
        else $error("rotation uses an unfinished factor");

    // gather sweep stays within its ten steps
    a_gather_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GATH) |-> (cnt_reg <= 4'd9))
        else $error("gather counter out of range");

    // a loaded result shows up as valid
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |=> rsp_valid_reg)
        else $error("loaded result not presented");

endmodule

>>> rtl/boris_particle_push.sv
// ---------------------------------------------------------------------------
// boris_particle_push
// Boris velocity push with trilinear E/B gather from an on-chip field memory.
// ---------------------------------------------------------------------------
// Each accepted transaction returns one result, in order. How long a push
// takes in the back end is set by the field memory's single read port (8
// corners times 6 components, 3 in electrostatic mode, one word a cycle), the
// one shared 34x33 multiplier that forms weights, gather products, the field
// scaling, cross products, |b|^2 and the rotation products, and the
// 32-step divider for 2/(1+|b|^2), which overlaps the second rotation. A
// two-entry queue sits in front, so requests are taken while a push is in
// progress, and the output register holds a result while the next item
// starts. The field memory is not cleared at reset; read only nodes that
// were written.
// ---------------------------------------------------------------------------
module boris_particle_push import bpp_pkg::*; #(
    parameter int GRID_N      = GRID_N_DEF,
    parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic                     cfg_index,
    input  logic [31:0]              cfg_data,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  logic                     req_type,
    input  logic [CELL_W-1:0]        cell_x,
    input  logic [CELL_W-1:0]        cell_y,
    input  logic [CELL_W-1:0]        cell_z,
    input  logic [FRAC_W-1:0]        frac_x,
    input  logic [FRAC_W-1:0]        frac_y,
    input  logic [FRAC_W-1:0]        frac_z,
    input  logic signed [VEL_W-1:0]  vel_x,
    input  logic signed [VEL_W-1:0]  vel_y,
    input  logic signed [VEL_W-1:0]  vel_z,
    input  logic [SEL_W-1:0]         field_select,
    input  logic signed [VEL_W-1:0]  field_value,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output logic signed [VEL_W-1:0]  new_vel_x,
    output logic signed [VEL_W-1:0]  new_vel_y,
    output logic signed [VEL_W-1:0]  new_vel_z,
    output logic [1:0]               push_status
);

    cfg_t  cfg_reg;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hqm    <= '0;
            cfg_reg.mag_en <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HQM: cfg_reg.hqm    <= cfg_data;
                CFG_MAG: cfg_reg.mag_en <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    bpp_front #(
        .GRID_N (GRID_N)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .cell_z       (cell_z),
        .frac_x       (frac_x),
        .frac_y       (frac_y),
        .frac_z       (frac_z),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .vel_z        (vel_z),
        .field_select (field_select),
        .field_value  (field_value),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item)
    );

    bpp_back #(
        .GRID_N      (GRID_N),
        .FIELD_WIDTH (FIELD_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .cfg         (cfg_reg),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .new_vel_x   (new_vel_x),
        .new_vel_y   (new_vel_y),
        .new_vel_z   (new_vel_z),
        .push_status (push_status)
    );

endmodule

>>> verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Boris particle push block: field writes and
// particle pushes are queued per configuration phase, driven in random
// bursts, and every response is checked against an in-bench fixed point
// predictor of the gather and the Boris rotation.
// ---------------------------------------------------------------------------
module tb_top import bpp_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID     = 32;
    localparam int STORE_SZ = COMP_NUM * GRID * GRID * GRID;
    localparam int WD_LIMIT = 20000;

    typedef struct {
        logic                    rt;
        logic [CELL_W-1:0]       cx, cy, cz;
        logic [FRAC_W-1:0]       fx, fy, fz;
        logic signed [VEL_W-1:0] vx, vy, vz;
        logic [SEL_W-1:0]        sel;
        logic signed [VEL_W-1:0] fv;
    } req_item_t;

    typedef struct {
        logic signed [VEL_W-1:0] vx, vy, vz;
        push_status_t            st;
    } push_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic cfg_index = CFG_HQM;
    logic [31:0] cfg_data = '0;
    logic req_valid = 1'b0;
    logic req_ready;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    logic signed [VEL_W-1:0] new_vel_x, new_vel_y, new_vel_z;
    logic [1:0] push_status;

    req_item_t cur = '{default: '0};
    req_item_t pend_q[$];
    push_rsp_t exp_rsp_q[$];

    // predictor state
    int signed   node_field[STORE_SZ];
    bit          gen_written[STORE_SZ];
    logic signed [31:0] hqm_reg = '0;
    logic        mag_reg = 1'b1;

    bit req_taken = 1'b0;
    int burst_left = 4;
    int gap_left = 0;
    int rdy_cnt = 0;
    int rdy_mode = 0;
    int idle_cycles = 0;
    int errors = 0;

    boris_particle_push dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .req_valid(req_valid), .req_ready(req_ready),
        .req_type(cur.rt),
        .cell_x(cur.cx), .cell_y(cur.cy), .cell_z(cur.cz),
        .frac_x(cur.fx), .frac_y(cur.fy), .frac_z(cur.fz),
        .vel_x(cur.vx), .vel_y(cur.vy), .vel_z(cur.vz),
        .field_select(cur.sel), .field_value(cur.fv),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
        .new_vel_x(new_vel_x), .new_vel_y(new_vel_y), .new_vel_z(new_vel_z),
        .push_status(push_status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int node_addr(int comp, int x, int y, int z);
        return ((comp * GRID + x) * GRID + y) * GRID + z;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v, inout bit hit);
        if (v > 64'sh7FFFFFFF)
        begin
            hit = 1'b1;
            return 64'sh7FFFFFFF;
        end
        if (v < -64'sh80000000)
        begin
            hit = 1'b1;
            return -64'sh80000000;
        end
        return v;
    endfunction

    // cross product in q32.32, rounded back to q16.16
    function automatic void cross_q16(input longint a[3], input longint b[3],
                                      output longint c[3], inout bit hit);
        c[0] = clamp32(rnd_shift(a[1] * b[2] - a[2] * b[1], 16), hit);
        c[1] = clamp32(rnd_shift(a[2] * b[0] - a[0] * b[2], 16), hit);
        c[2] = clamp32(rnd_shift(a[0] * b[1] - a[1] * b[0], 16), hit);
    endfunction

    // gather plus boris rotation for one transaction
    function automatic push_rsp_t boris_predict(req_item_t it);
        push_rsp_t r;
        longint v[3], e[3], b[3], v1[3], vt[3], c[3];
        longint unsigned w[2][3], wt[8], den, factor;
        longint acc, g;
        bit hit;
        int x, y, z;
        r.vx = '0; r.vy = '0; r.vz = '0; r.st = STATUS_OK;
        hit = 1'b0;
        if (it.rt == REQ_WRITE)
        begin
            if (it.sel < COMP_NUM)
                node_field[node_addr(int'(it.sel), int'(it.cx), int'(it.cy), int'(it.cz))]
                    = it.fv;
            return r;
        end
        v[0] = longint'(it.vx); v[1] = longint'(it.vy); v[2] = longint'(it.vz);
        if (it.cx + 1 >= GRID || it.cy + 1 >= GRID || it.cz + 1 >= GRID)
        begin
            r.vx = it.vx; r.vy = it.vy; r.vz = it.vz; r.st = STATUS_OUTSIDE;
            return r;
        end
        w[1][0] = 64'(it.fx); w[1][1] = 64'(it.fy); w[1][2] = 64'(it.fz);
        for (int i = 0; i < 3; i++)
            w[0][i] = 65536 - w[1][i];
        for (int k = 0; k < 8; k++)
            wt[k] = (w[k & 1][0] * w[(k >> 1) & 1][1] * w[(k >> 2) & 1][2]) >> 24;
        for (int comp = 0; comp < COMP_NUM; comp++)
        begin
            if (comp >= 3 && !mag_reg)
            begin
                b[comp - 3] = 0;
                continue;
            end
            acc = 0;
            for (int k = 0; k < 8; k++)
            begin
                x = int'(it.cx) + (k & 1);
                y = int'(it.cy) + ((k >> 1) & 1);
                z = int'(it.cz) + ((k >> 2) & 1);
                acc += longint'(wt[k]) * longint'(node_field[node_addr(comp, x, y, z)]);
            end
            g = rnd_shift(acc, 24);
            g = clamp32(rnd_shift(g * longint'(hqm_reg), 24), hit);
            if (comp < 3)
                e[comp] = g;
            else
                b[comp - 3] = g;
        end
        for (int i = 0; i < 3; i++)
            v1[i] = clamp32(v[i] + e[i], hit);
        cross_q16(v1, b, c, hit);
        for (int i = 0; i < 3; i++)
            vt[i] = clamp32(v1[i] + c[i], hit);
        den = 64'd1 << 32;
        for (int i = 0; i < 3; i++)
            den += longint'(b[i] * b[i]);
        factor = (64'd1 << 63) / den;
        cross_q16(vt, b, c, hit);
        for (int i = 0; i < 3; i++)
            v[i] = clamp32(v1[i] + e[i] + rnd_shift(c[i] * longint'(factor), 30), hit);
        r.vx = 32'(v[0]); r.vy = 32'(v[1]); r.vz = 32'(v[2]);
        r.st = hit ? STATUS_SAT : STATUS_OK;
        return r;
    endfunction

    // field words: mostly a few units, sometimes full range or extremes
    function automatic logic signed [31:0] rand_field();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_vel();
        if ($urandom_range(0, 2) == 0)
            return $urandom;
        return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    endfunction

    function automatic void queue_write(int sel, int x, int y, int z, logic signed [31:0] fv);
        req_item_t it;
        it = '{default: '0};
        it.rt = REQ_WRITE;
        it.sel = SEL_W'(sel);
        it.cx = CELL_W'(x); it.cy = CELL_W'(y); it.cz = CELL_W'(z);
        it.fv = fv;
        it.fx = FRAC_W'($urandom); it.vx = $urandom;
        if (sel < COMP_NUM)
            gen_written[node_addr(sel, x, y, z)] = 1'b1;
        pend_q = {pend_q, it};
    endfunction

    // a push inside the grid first fills any corner word not yet written
    function automatic void queue_push(int x, int y, int z, logic [15:0] fx,
                                       logic [15:0] fy, logic [15:0] fz,
                                       logic signed [31:0] vx, logic signed [31:0] vy,
                                       logic signed [31:0] vz);
        req_item_t it;
        if (x + 1 < GRID && y + 1 < GRID && z + 1 < GRID)
            for (int comp = 0; comp < COMP_NUM; comp++)
                for (int k = 0; k < 8; k++)
                    if (!gen_written[node_addr(comp, x + (k & 1), y + ((k >> 1) & 1),
                                               z + ((k >> 2) & 1))])
                        queue_write(comp, x + (k & 1), y + ((k >> 1) & 1),
                                    z + ((k >> 2) & 1), rand_field());
        it = '{default: '0};
        it.rt = REQ_PUSH;
        it.cx = CELL_W'(x); it.cy = CELL_W'(y); it.cz = CELL_W'(z);
        it.fx = fx; it.fy = fy; it.fz = fz;
        it.vx = vx; it.vy = vy; it.vz = vz;
        it.sel = SEL_W'($urandom); it.fv = $urandom;
        pend_q = {pend_q, it};
    endfunction

    // base cells stay inside one of two small regions, near and far corner
    function automatic int rand_cell(int base);
        return base + $urandom_range(0, 2);
    endfunction

    // random mix of writes, outside pushes and well-formed pushes
    function automatic void queue_random(int n);
        int r;
        int base;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                queue_write($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 31),
                            $urandom_range(0, 31), rand_field());
            else if (r < 40)
                queue_push($urandom_range(0, 2) == 0 ? 31 : $urandom_range(0, 31),
                           $urandom_range(0, 1) ? 31 : $urandom_range(0, 31), 31,
                           16'($urandom), 16'($urandom), 16'($urandom),
                           $urandom, $urandom, $urandom);
            else
            begin
                base = ($urandom_range(0, 6) == 0) ? GRID - 4 : 0;
                queue_push(rand_cell(base), rand_cell(base), rand_cell(base),
                           16'($urandom), 16'($urandom), 16'($urandom),
                           rand_vel(), rand_vel(), rand_vel());
            end
        end
    endfunction

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == CFG_HQM)
            hqm_reg = val;
        else
            mag_reg = val[0];
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || exp_rsp_q.size() > 0 || req_valid)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_taken))
        begin
            req_taken = 1'b0;
            if (gap_left > 0)
            begin
                req_valid = 1'b0;
                gap_left--;
            end
            else if (pend_q.size() > 0)
            begin
                cur = pend_q.pop_front();
                req_valid = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                req_valid = 1'b0;
        end
    end

    // receiver: the stall pattern is redrawn at random, from four modes
    always @(negedge clk)
    begin
        rdy_cnt++;
        if (rdy_cnt % 64 == 0)
            rdy_mode = $urandom_range(0, 3);
        case (rdy_mode)
            0: rsp_ready = 1'b1;
            1: rsp_ready = 1'($urandom_range(0, 1));
            2: rsp_ready = (rdy_cnt % 4 == 0);
            default: rsp_ready = ($urandom_range(0, 7) != 0);
        endcase
    end

    // request acceptance, response check and watchdog
    always @(posedge clk)
    begin
        push_rsp_t ex;
        if (rst_n)
        begin
            idle_cycles++;
            if (req_valid && req_ready)
            begin
                req_taken = 1'b1;
                exp_rsp_q = {exp_rsp_q, boris_predict(cur)};
                idle_cycles = 0;
            end
            if (rsp_valid && rsp_ready)
            begin
                idle_cycles = 0;
                if (exp_rsp_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction vel %h %h %h status %0d", $time,
                             new_vel_x, new_vel_y, new_vel_z, push_status);
                end
                else
                begin
                    ex = exp_rsp_q.pop_front();
                    if (new_vel_x !== ex.vx || new_vel_y !== ex.vy || new_vel_z !== ex.vz
                        || push_status !== ex.st)
                    begin
                        errors++;
                        $display("%0t: expected %h %h %h st %0d, got %h %h %h st %0d",
                                 $time, ex.vx, ex.vy, ex.vz, ex.st,
                                 new_vel_x, new_vel_y, new_vel_z, push_status);
                    end
                end
            end
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset register values
        queue_random(100);
        drain();

        // directed: unit scaling, electromagnetic
        write_reg(CFG_HQM, 32'h0100_0000);
        write_reg(CFG_MAG, 1'b1);
        queue_push(0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
        queue_write(0, 1, 1, 1, 32'sh7FFFFFFF);
        queue_write(3, 1, 1, 1, 32'sh80000000);
        queue_write(6, 2, 2, 2, 32'sh12345678);
        queue_write(7, 31, 31, 31, 32'sh7FFFFFFF);
        queue_push(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        queue_push(0, 0, 0, 16'h8000, 16'h0000, 16'hFFFF,
                   32'sh80000000, 32'sh7FFFFFFF, 0);
        queue_push(0, 0, 0, 16'h0001, 16'h7FFF, 16'hFFFE, 32'h0001_0000, -32'sh10000, 1);
        queue_push(31, 0, 0, 16'h1234, 16'h0, 16'h0, 32'sh7FFFFFFF, 5, -5);
        queue_push(0, 31, 0, 16'h0, 16'hFFFF, 16'h0, 32'sh80000000, 0, 0);
        queue_push(0, 0, 31, 16'h0, 16'h0, 16'hFFFF, 1, 2, 3);
        queue_push(30, 30, 30, 16'hFFFF, 16'h0, 16'h8000, 32'h0002_0000, 0, -1);
        queue_random(180);
        drain();

        // extremes of the scale factor
        write_reg(CFG_HQM, 32'h7FFF_FFFF);
        queue_random(170);
        drain();
        write_reg(CFG_HQM, 32'h8000_0000);
        write_reg(CFG_MAG, 1'b0);
        queue_random(170);
        drain();

        // electrostatic with unit scale, then electromagnetic with small and random scales
        write_reg(CFG_HQM, 32'h0100_0000);
        queue_random(170);
        drain();
        write_reg(CFG_HQM, $signed($urandom_range(0, 1 << 26)) - (1 << 25));
        write_reg(CFG_MAG, 1'b1);
        queue_random(210);
        drain();
        write_reg(CFG_HQM, $urandom);
        queue_random(170);
        drain();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
